[sv/assert_macros.svh]
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define SMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// cons must hold in the cycle after ante
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sms_pkg.sv]
// ------------------------------------------------------------------------
// sms_pkg
// Types and constants shared by the sorted matrix search block.
// ------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

	localparam int CNT_W  = 7;   // row/column count registers
	localparam int IDX_W  = 6;   // row/column index of a write item
	localparam int VAL_W  = 32;  // value field
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register indexes (paddr[2])
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	// request codes
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] row_count;
		logic [CNT_W-1:0] column_count;
	} cfg_t;

endpackage

`default_nettype wire

[sv/sms_ram.sv]
// ------------------------------------------------------------------------
// sms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ------------------------------------------------------------------------
`default_nettype none

module sms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/sms_cfg.sv]
// ------------------------------------------------------------------------
// sms_cfg
// APB register file: row count at 0x0, column count at 0x4.
// ------------------------------------------------------------------------
`default_nettype none

module sms_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sms_pkg::APB_AW-1:0] paddr,
	input  wire logic [sms_pkg::APB_DW-1:0] pwdata,
	output logic      [sms_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output sms_pkg::cfg_t                   cfg
);

	sms_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				sms_pkg::REG_ROW_COUNT: begin
					cfg_q.row_count <= pwdata[sms_pkg::CNT_W-1:0];
				end
				sms_pkg::REG_COLUMN_COUNT: begin
					cfg_q.column_count <= pwdata[sms_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			sms_pkg::REG_ROW_COUNT:    prdata[sms_pkg::CNT_W-1:0] = cfg_q.row_count;
			sms_pkg::REG_COLUMN_COUNT: prdata[sms_pkg::CNT_W-1:0] = cfg_q.column_count;
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[sv/sms_ctrl.sv]
// ------------------------------------------------------------------------
// sms_ctrl
// Item control: stores write items, runs the two binary searches as
// probe/compare steps against the matrix RAM.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sms_ctrl #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int DATA_WIDTH = 32,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sms_pkg::cfg_t             cfg,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      req_type,
	input  wire logic [sms_pkg::IDX_W-1:0] row_index,
	input  wire logic [sms_pkg::IDX_W-1:0] col_index,
	input  wire logic [sms_pkg::VAL_W-1:0] value,
	output logic                           done,
	output logic                           found,
	output logic                           ram_we,
	output logic      [AW-1:0]             ram_waddr,
	output logic      [DATA_WIDTH-1:0]     ram_wdata,
	output logic                           ram_re,
	output logic      [AW-1:0]             ram_raddr,
	input  wire logic [DATA_WIDTH-1:0]     ram_rdata
);

	localparam int CW      = sms_pkg::CNT_W;
	localparam int CNT_MAX = (1 << CW) - 1;
	localparam int ROW_LIM = (MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > CNT_MAX) ? CNT_MAX : MAX_COLS;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_BACK, S_COMPARE} state_t;
	// what the pending probe means
	typedef enum logic [1:0] {K_MID, K_ROW_END, K_ROW_BACK, K_COL_END} kind_t;

	state_t                        state_q;
	kind_t                         kind_q;
	logic                          col_phase_q;
	logic   [CW-1:0]               lo_q;
	logic   [CW-1:0]               hi_q;
	logic   [CW-1:0]               mid_q;
	logic   [CW-1:0]               row_q;
	logic signed [DATA_WIDTH-1:0]  target_q;
	logic                          done_q;
	logic                          found_q;

	logic                          accept;
	logic   [CW-1:0]               rows_eff;
	logic   [CW-1:0]               cols_eff;
	logic signed [63:0]            value_ext;
	logic signed [DATA_WIDTH-1:0]  target_in;
	logic signed [DATA_WIDTH-1:0]  entry_s;
	logic                          lt;
	logic                          eq;
	logic   [CW:0]                 sum;
	logic   [CW-1:0]               mid_c;
	logic   [CW-1:0]               probe_idx;
	logic   [CW-1:0]               probe_row;
	logic   [CW-1:0]               probe_col;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign found  = found_q;

	assign rows_eff = (cfg.row_count > CW'(ROW_LIM)) ? CW'(ROW_LIM) : cfg.row_count;
	assign cols_eff = (cfg.column_count > CW'(COL_LIM)) ? CW'(COL_LIM) : cfg.column_count;

	// value is sign-extended, then cut to the stored word width
	assign value_ext = {{(64 - sms_pkg::VAL_W){value[sms_pkg::VAL_W-1]}}, value};
	assign target_in = value_ext[DATA_WIDTH-1:0];

	assign entry_s = ram_rdata;
	assign lt      = target_q < entry_s;
	assign eq      = target_q == entry_s;

	assign sum       = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c     = sum[CW:1];
	assign probe_idx = (lo_q < hi_q) ? mid_c : lo_q;

	always_comb begin
		probe_row = row_q;
		probe_col = '0;
		case (state_q)
			S_ISSUE: begin
				if (col_phase_q) begin
					probe_col = probe_idx;
				end else begin
					probe_row = probe_idx;
				end
			end
			default: begin
				probe_row = row_q;
			end
		endcase
	end

	assign ram_re    = (state_q == S_ISSUE) || (state_q == S_BACK);
	assign ram_raddr = AW'(int'(probe_row) * MAX_COLS + int'(probe_col));

	// writes land only in IDLE, so they never overlap a search read
	assign ram_we    = accept && (req_type == sms_pkg::REQ_WRITE)
		&& (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
	assign ram_waddr = AW'(int'(row_index) * MAX_COLS + int'(col_index));
	assign ram_wdata = target_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_MID;
			col_phase_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			row_q       <= '0;
			target_q    <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && req_type == sms_pkg::REQ_SEARCH) begin
						target_q <= target_in;
						if (rows_eff == '0 || cols_eff == '0) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
						end else begin
							lo_q        <= '0;
							hi_q        <= rows_eff - 1'b1;
							col_phase_q <= 1'b0;
							state_q     <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					mid_q <= mid_c;
					if (lo_q < hi_q) begin
						kind_q <= K_MID;
					end else if (col_phase_q) begin
						kind_q <= K_COL_END;
					end else begin
						kind_q <= K_ROW_END;
					end
					state_q <= S_COMPARE;
				end
				S_BACK: begin
					kind_q  <= K_ROW_BACK;
					state_q <= S_COMPARE;
				end
				S_COMPARE: begin
					unique case (kind_q)
						K_MID: begin
							if (eq) begin
								done_q  <= 1'b1;
								found_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								if (lt) begin
									hi_q <= mid_q;
								end else begin
									lo_q <= mid_q + 1'b1;
								end
								state_q <= S_ISSUE;
							end
						end
						K_ROW_END: begin
							if (eq) begin
								done_q  <= 1'b1;
								found_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (lt) begin
								if (lo_q == '0) begin
									done_q  <= 1'b1;
									found_q <= 1'b0;
									state_q <= S_IDLE;
								end else begin
									// step back one row and check its head
									row_q   <= lo_q - 1'b1;
									state_q <= S_BACK;
								end
							end else begin
								row_q       <= lo_q;
								col_phase_q <= 1'b1;
								lo_q        <= '0;
								hi_q        <= cols_eff - 1'b1;
								state_q     <= S_ISSUE;
							end
						end
						K_ROW_BACK: begin
							if (eq || lt) begin
								done_q  <= 1'b1;
								found_q <= eq;
								state_q <= S_IDLE;
							end else begin
								col_phase_q <= 1'b1;
								lo_q        <= '0;
								hi_q        <= cols_eff - 1'b1;
								state_q     <= S_ISSUE;
							end
						end
						K_COL_END: begin
							done_q  <= 1'b1;
							found_q <= eq;
							state_q <= S_IDLE;
						end
					endcase
				end
			endcase
		end
	end

	`SMS_ASSERT(a_done_when_idle, done_q |-> !busy, "result strobe while a search is running")
	`SMS_ASSERT_NEXT(a_search_starts, accept && req_type == sms_pkg::REQ_SEARCH && rows_eff != '0 && cols_eff != '0, busy, "nonempty search did not start")
	`SMS_ASSERT(a_bounds_ordered, (state_q == S_ISSUE) |-> (lo_q <= hi_q), "search bounds crossed")

endmodule

`default_nettype wire

[sv/sorted_matrix_search.sv]
// ------------------------------------------------------------------------
// sorted_matrix_search
// Writes are stored from IDLE; each search probe is an issue (or back) step, then a compare step.
// Probes: at most ceil(log2 rows) + 1 or 2 + ceil(log2 cols) + 1; done follows the last compare.
// Empty-matrix search: done the cycle after start. Reset clears regs and control; RAM undefined.
// ------------------------------------------------------------------------
`default_nettype none

module sorted_matrix_search #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sms_pkg::APB_AW-1:0] paddr,
	input  wire logic [sms_pkg::APB_DW-1:0] pwdata,
	output logic      [sms_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       req_type,
	input  wire logic [sms_pkg::IDX_W-1:0]  row_index,
	input  wire logic [sms_pkg::IDX_W-1:0]  col_index,
	input  wire logic [sms_pkg::VAL_W-1:0]  value,
	output logic                            done,
	output logic                            found
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sms_pkg::cfg_t          cfg;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DATA_WIDTH-1:0]  ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [DATA_WIDTH-1:0]  ram_rdata;

	sms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sms_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sms_ctrl #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.done      (done),
		.found     (found),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

[tb/sv/sms_search_checker.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// sms_search_checker
// Watches the register port and the item channel of the sorted matrix
// search block, keeps its own copy of the matrix and the row/column
// counts, predicts the found flag of every accepted search and compares
// it with each result the block strobes out.
// ------------------------------------------------------------------------

module sms_search_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sms_pkg::APB_AW-1:0] paddr,
	input  logic [sms_pkg::APB_DW-1:0] pwdata,
	input  logic                       pready,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       req_type,
	input  logic [sms_pkg::IDX_W-1:0]  row_index,
	input  logic [sms_pkg::IDX_W-1:0]  col_index,
	input  logic [sms_pkg::VAL_W-1:0]  value,
	input  logic                       done,
	input  logic                       found,
	output int                         error_count,
	output int                         pending_count,
	output int                         result_count,
	output int                         hit_count
);
	import sms_pkg::*;

	localparam int ROWS_MAX   = 64;
	localparam int COLS_MAX   = 64;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic             found;
		logic [VAL_W-1:0] target;
	} search_answer_t;

	logic signed [VAL_W-1:0] matrix_words [ROWS_MAX*COLS_MAX];
	logic [CNT_W-1:0]        row_cfg;
	logic [CNT_W-1:0]        col_cfg;
	search_answer_t          expected_found_q [$];
	search_answer_t          answer;

	initial begin
		foreach (matrix_words[i])
			matrix_words[i] = '0;
		error_count   = 0;
		pending_count = 0;
		result_count  = 0;
		hit_count     = 0;
	end

	function automatic logic signed [VAL_W-1:0] word_at(input int unsigned r, input int unsigned c);
		return matrix_words[r*COLS_MAX + c];
	endfunction

	// row search on column 0, then column search in the chosen row
	function automatic logic predict_found(input logic signed [VAL_W-1:0] target);
		int unsigned nrows, ncols, lo, hi, mid, hit_row;
		nrows = (row_cfg > ROWS_MAX) ? ROWS_MAX : row_cfg;
		ncols = (col_cfg > COLS_MAX) ? COLS_MAX : col_cfg;
		if (nrows == 0 || ncols == 0)
			return 1'b0;
		lo = 0;
		hi = nrows - 1;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (target < word_at(mid, 0))
				hi = mid;
			else if (target > word_at(mid, 0))
				lo = mid + 1;
			else
				return 1'b1;
		end
		hit_row = lo;
		if (hit_row == 0) begin
			if (target < word_at(0, 0))
				return 1'b0;
		end else if (target < word_at(hit_row, 0)) begin
			hit_row--;
		end else if (target == word_at(hit_row, 0)) begin
			return 1'b1;
		end
		if (target < word_at(hit_row, 0))
			return 1'b0;
		if (target == word_at(hit_row, 0))
			return 1'b1;
		lo = 0;
		hi = ncols - 1;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (target < word_at(hit_row, mid))
				hi = mid;
			else if (target > word_at(hit_row, mid))
				lo = mid + 1;
			else
				return 1'b1;
		end
		return target == word_at(hit_row, lo);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cfg = '0;
			col_cfg = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ROW_COUNT)
					row_cfg = pwdata[CNT_W-1:0];
				else
					col_cfg = pwdata[CNT_W-1:0];
			end
			if (done) begin
				if (expected_found_q.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("tb: unexpected result, found=%0b with no search pending", found);
				end else begin
					answer = expected_found_q.pop_front();
					result_count++;
					if (found !== answer.found) begin
						error_count++;
						if (error_count <= REPORT_MAX)
							$display("tb: target %0d: found expected %0b, got %0b",
								$signed(answer.target), answer.found, found);
					end else if (found) begin
						hit_count++;
					end
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE) begin
					matrix_words[row_index*COLS_MAX + col_index] = value;
				end else begin
					answer.target = value;
					answer.found  = predict_found(value);
					expected_found_q.insert(expected_found_q.size(), answer);
				end
			end
			pending_count = expected_found_q.size();
		end
	end

endmodule

[tb/sv/sorted_matrix_search_tb.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// sorted_matrix_search_tb
// Sets matrix shapes over the register port, fills each shape with sorted
// random contents, then fires searches at hits, near misses, values off
// both ends and random values, with stray and unsorted writes mixed in.
// The checker beside the block predicts and compares every result.
// ------------------------------------------------------------------------

module sorted_matrix_search_tb;
	import sms_pkg::*;

	localparam int DIM_MAX      = 64;
	localparam int QUIET_CYCLES = 40;
	localparam int ITEM_TARGET  = 1700;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start     = 1'b0;
	logic              busy;
	logic              req_type  = REQ_WRITE;
	logic [IDX_W-1:0]  row_index = '0;
	logic [IDX_W-1:0]  col_index = '0;
	logic [VAL_W-1:0]  value     = '0;
	logic              done;
	logic              found;

	int error_count;
	int pending_count;
	int result_count;
	int hit_count;

	logic signed [VAL_W-1:0] shadow [DIM_MAX*DIM_MAX];
	int shape_rows   = 0;
	int shape_cols   = 0;
	int write_items  = 0;
	int search_items = 0;
	int phase_count  = 0;
	int cycle_count  = 0;
	bit burst_mode   = 1'b0;

	always #5 clk = ~clk;

	sorted_matrix_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.row_index(row_index),
		.col_index(col_index),
		.value    (value),
		.done     (done),
		.found    (found)
	);

	sms_search_checker search_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.row_index    (row_index),
		.col_index    (col_index),
		.value        (value),
		.done         (done),
		.found        (found),
		.error_count  (error_count),
		.pending_count(pending_count),
		.result_count (result_count),
		.hit_count    (hit_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int gap_len();
		int roll;
		if (burst_mode)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// start stays high across back-to-back items; one assignment per edge
	task automatic send_item(input logic kind, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req_type  <= kind;
		row_index <= r;
		col_index <= c;
		value     <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (kind == REQ_WRITE)
			write_items++;
		else
			search_items++;
	endtask

	task automatic write_entry(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input logic [VAL_W-1:0] v);
		shadow[r*DIM_MAX + c] = v;
		send_item(REQ_WRITE, r, c, v);
	endtask

	task automatic search_for(input logic [VAL_W-1:0] v);
		send_item(REQ_SEARCH, IDX_W'($urandom()), IDX_W'($urandom()), v);
	endtask

	// wait out all pending results plus the longest search
	task automatic settle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0 || busy);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input int unsigned v);
		logic [APB_DW-1:0] data;
		data = $urandom();
		data[CNT_W-1:0] = v[CNT_W-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(input int rows, input int cols);
		settle();
		reg_write(REG_ROW_COUNT, rows);
		reg_write(REG_COLUMN_COUNT, cols);
		shape_rows = (rows > DIM_MAX) ? DIM_MAX : rows;
		shape_cols = (cols > DIM_MAX) ? DIM_MAX : cols;
		burst_mode = ($urandom_range(0, 3) == 0);
		phase_count++;
	endtask

	// row-major ascending contents; some sets span the full value range
	task automatic fill_region();
		longint lo_val, hi_val, acc;
		longint unsigned span, step_max;
		int n, roll, k;
		bit span_full;
		n = shape_rows * shape_cols;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			step_max = 1;
		else if (roll < 6)
			step_max = 1000;
		else
			step_max = 64'h1_0000_0000 / (n + 1);
		lo_val = -64'sd2147483648;
		hi_val = 64'sd2147483647 - longint'(step_max) * n;
		span = hi_val - lo_val + 1;
		acc = lo_val + longint'({$urandom(), $urandom()} % span);
		span_full = ($urandom_range(0, 6) == 0);
		k = 0;
		for (int r = 0; r < shape_rows; r++) begin
			for (int c = 0; c < shape_cols; c++) begin
				if (k > 0)
					acc += longint'((step_max == 1) ? $urandom_range(0, 1)
						: $urandom_range(1, int'(step_max)));
				if (span_full && k == 0)
					write_entry(IDX_W'(r), IDX_W'(c), VAL_MIN);
				else if (span_full && k == n - 1)
					write_entry(IDX_W'(r), IDX_W'(c), VAL_MAX);
				else
					write_entry(IDX_W'(r), IDX_W'(c), acc[VAL_W-1:0]);
				k++;
			end
		end
	endtask

	function automatic logic [VAL_W-1:0] pick_target();
		int roll;
		logic signed [VAL_W-1:0] w;
		roll = $urandom_range(0, 99);
		if (shape_rows == 0 || shape_cols == 0)
			return (roll < 25) ? ((roll < 12) ? VAL_MIN : VAL_MAX) : $urandom();
		w = shadow[$urandom_range(0, shape_rows - 1)*DIM_MAX
			+ $urandom_range(0, shape_cols - 1)];
		if (roll < 40)
			return w;
		if (roll < 55)
			return $urandom_range(0, 1) ? w + 1 : w - 1;
		if (roll < 65)
			return shadow[0] - $urandom_range(1, 50);
		if (roll < 75)
			return shadow[(shape_rows - 1)*DIM_MAX + shape_cols - 1] + $urandom_range(1, 50);
		if (roll < 90)
			return $urandom();
		return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
	endfunction

	task automatic run_phase(input int rows, input int cols);
		int strays, searches;
		set_shape(rows, cols);
		if (shape_rows != 0 && shape_cols != 0)
			fill_region();
		strays = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		repeat (strays)
			write_entry(IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
		searches = $urandom_range(8, 30);
		repeat (searches) begin
			// occasional overwrite inside the shape breaks the ordering
			if (shape_rows != 0 && shape_cols != 0 && $urandom_range(0, 19) == 0)
				write_entry(IDX_W'($urandom_range(0, shape_rows - 1)),
					IDX_W'($urandom_range(0, shape_cols - 1)), $urandom());
			search_for(pick_target());
		end
	endtask

	task automatic random_phase();
		int roll, rows, cols;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			if ($urandom_range(0, 1)) begin
				rows = 0;
				cols = $urandom_range(0, 127);
			end else begin
				rows = $urandom_range(0, 127);
				cols = 0;
			end
		end else if (roll < 11) begin
			rows = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
			cols = $urandom_range(1, 2);
		end else if (roll < 16) begin
			rows = $urandom_range(1, 2);
			cols = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
		end else if (roll < 26) begin
			rows = $urandom_range(1, 16);
			cols = $urandom_range(1, 16);
		end else begin
			rows = $urandom_range(1, 8);
			cols = $urandom_range(1, 8);
		end
		run_phase(rows, cols);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// counts are zero out of reset: empty matrix
		search_for(32'd0);
		search_for(VAL_MIN);
		search_for(VAL_MAX);
		set_shape(3, 0);
		search_for($urandom());
		set_shape(0, 3);
		search_for($urandom());

		set_shape(1, 1);
		write_entry(0, 0, 32'd100);
		search_for(32'd99);
		search_for(32'd100);
		search_for(32'd101);
		search_for(VAL_MIN);
		search_for(VAL_MAX);

		set_shape(2, 2);
		write_entry(0, 0, VAL_MIN);
		write_entry(0, 1, -32'sd5);
		write_entry(1, 0, 32'sd7);
		write_entry(1, 1, VAL_MAX);
		search_for(VAL_MIN);
		search_for(-32'sd5);
		search_for(-32'sd6);
		search_for(32'd0);
		search_for(32'sd7);
		search_for(VAL_MAX);

		// tall, wide and oversized shapes first, then random ones
		run_phase(64, 2);
		run_phase(127, 1);
		run_phase(2, 64);
		run_phase(1, 127);
		while (write_items + search_items < ITEM_TARGET)
			random_phase();
		settle();

		$display("tb: %0d shapes, %0d writes, %0d searches, %0d results checked, %0d found",
			phase_count, write_items, search_items, result_count, hit_count);
		$display("tb: shapes ran from empty to 64 rows or columns and oversized counts");
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/sms_pkg.sv
sv/sms_ram.sv
sv/sms_cfg.sv
sv/sms_ctrl.sv
sv/sorted_matrix_search.sv
tb/sv/sms_search_checker.sv
tb/sv/sorted_matrix_search_tb.sv
